// File: rtl/mvm_pkg.sv
// Shared constants and types for the matrix-vector multiplier.
package mvm_pkg;

    localparam int MAX_COLS   = 256;
    localparam int COL_AW     = $clog2(MAX_COLS);
    localparam int COLS_W     = 9;
    localparam int ROWS_W     = 16;
    localparam int IDX_W      = 8;
    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int SUM_W      = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'd1;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_MATRIX = 1'b1;

    // Row bookkeeping that travels alongside each matrix element.
    typedef struct packed {
        logic              end_of_row;
        logic              last_row;
        logic [ROWS_W-1:0] row_index;
    } row_tag_t;

endpackage

// File: rtl/mvm_mac.sv
// Multiply-accumulate and result register of the matrix-vector multiplier.
module mvm_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                elem_valid,
    input  logic signed [mvm_pkg::ELEM_W-1:0]   elem_value,
    input  logic signed [mvm_pkg::ELEM_W-1:0]   vec_value,
    input  mvm_pkg::row_tag_t                   elem_tag,
    output logic                                res_valid,
    output logic        [mvm_pkg::SUM_W-1:0]    res_sum,
    output mvm_pkg::row_tag_t                   res_tag
);

    logic signed [mvm_pkg::PROD_W-1:0]   prod;
    logic        [mvm_pkg::SUM_W-1:0]    sum_reg;
    logic        [mvm_pkg::SUM_W-1:0]    sum_next;
    logic                                res_valid_reg;
    logic        [mvm_pkg::SUM_W-1:0]    res_sum_reg;
    mvm_pkg::row_tag_t                   res_tag_reg;

    // Exact Q8.24 product of the two Q4.12 operands.
    assign prod = elem_value * vec_value;

    // Sign-extend the product and add it to the running sum; wraps modulo 2^40.
    assign sum_next = sum_reg
                    + {{(mvm_pkg::SUM_W - mvm_pkg::PROD_W){prod[mvm_pkg::PROD_W-1]}},
                       prod};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else if (advance)
        begin
            res_valid_reg <= elem_valid && elem_tag.end_of_row;
            if (elem_valid)
            begin
                sum_reg <= elem_tag.end_of_row ? '0 : sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && elem_valid && elem_tag.end_of_row)
        begin
            res_sum_reg <= sum_next;
            res_tag_reg <= elem_tag;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_sum   = res_sum_reg;
    assign res_tag   = res_tag_reg;

endmodule

// File: rtl/matrix_vector_multiply.sv
// Top level of the streaming row-major matrix-vector multiplier.
//
// Load the vector first with beats whose tuser is 0: each writes one signed
// Q4.12 element into a 256-entry store at tdata's index. Then stream the
// matrix in row-major order with tuser set to 1. Every matrix beat is
// multiplied by the stored element of its column and added into a 40-bit
// Q16.24 sum; after the last column of a row one result beat carries the
// row index and dot product, with tlast on the final row of the matrix,
// after which the row count wraps and the same vector serves the next
// matrix. One beat is taken every clock cycle when the output is not
// stalled; a result is offered once the beat that ends its row has passed
// the input register (store read) and then the result register (one
// multiply-accumulate). The whole pipeline, input included, holds only
// while a result beat waits unaccepted. Every column's element must be
// loaded before it is used. cols_in_use (register 0) of 0 acts as 1 and
// above 256 acts as 256; rows_in_use (register 1) of 0 acts as 1. Write the
// registers only while no beat is in flight; they are taken every cycle.
module matrix_vector_multiply (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [7:0] vector_index, [23:8] element_value
    input  logic        s_axis_tuser,  // [0] kind: 0 load vector, 1 matrix element
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // [15:0] row_index, [55:16] dot_product
    output logic        m_axis_tlast,  // last_row
    // Register writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                              advance;
    logic                              beat;
    logic                              load_beat;
    logic                              elem_beat;
    logic [mvm_pkg::IDX_W-1:0]         in_index;
    logic [mvm_pkg::ELEM_W-1:0]        in_value;

    logic [mvm_pkg::COLS_W-1:0]        cols_reg;
    logic [mvm_pkg::ROWS_W-1:0]        rows_reg;
    logic [mvm_pkg::COLS_W-1:0]        cols_eff;
    logic [mvm_pkg::ROWS_W-1:0]        rows_eff;

    logic [mvm_pkg::COL_AW-1:0]        col_cnt_reg;
    logic [mvm_pkg::ROWS_W-1:0]        row_cnt_reg;
    logic                              row_done;
    logic                              is_last_row;

    logic [mvm_pkg::ELEM_W-1:0]        vec_mem [mvm_pkg::MAX_COLS];
    logic [mvm_pkg::ELEM_W-1:0]        vec_rd_reg;

    logic                              elem_valid_reg;
    logic [mvm_pkg::ELEM_W-1:0]        elem_value_reg;
    mvm_pkg::row_tag_t                 elem_tag_reg;
    mvm_pkg::row_tag_t                 elem_tag_next;

    logic [mvm_pkg::SUM_W-1:0]         res_sum;
    mvm_pkg::row_tag_t                 res_tag;

    // Whole pipeline moves together; hold everything only while a result stalls.
    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;
    assign beat          = s_axis_tvalid && s_axis_tready;
    assign load_beat     = beat && (s_axis_tuser == mvm_pkg::KIND_LOAD);
    assign elem_beat     = beat && (s_axis_tuser == mvm_pkg::KIND_MATRIX);
    assign in_index      = s_axis_tdata[mvm_pkg::IDX_W-1:0];
    assign in_value      = s_axis_tdata[mvm_pkg::IDX_W +: mvm_pkg::ELEM_W];

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= mvm_pkg::COLS_W'(256);
            rows_reg <= mvm_pkg::ROWS_W'(256);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mvm_pkg::CFG_COLS_IN_USE: cols_reg <= cfg_data[mvm_pkg::COLS_W-1:0];
                mvm_pkg::CFG_ROWS_IN_USE: rows_reg <= cfg_data[mvm_pkg::ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the programmed counts to what the store and the counters allow.
    always_comb
    begin
        if (cols_reg == '0)
        begin
            cols_eff = mvm_pkg::COLS_W'(1);
        end
        else if (cols_reg > mvm_pkg::COLS_W'(mvm_pkg::MAX_COLS))
        begin
            cols_eff = mvm_pkg::COLS_W'(mvm_pkg::MAX_COLS);
        end
        else
        begin
            cols_eff = cols_reg;
        end
        rows_eff = (rows_reg == '0) ? mvm_pkg::ROWS_W'(1) : rows_reg;
    end

    // A row ends when the column about to be used is the last one in use.
    assign row_done    = (mvm_pkg::COLS_W'(col_cnt_reg) + mvm_pkg::COLS_W'(1)) >= cols_eff;
    assign is_last_row = row_cnt_reg >= (rows_eff - mvm_pkg::ROWS_W'(1));

    always_comb
    begin
        elem_tag_next.end_of_row = row_done;
        elem_tag_next.last_row   = is_last_row;
        elem_tag_next.row_index  = row_cnt_reg;
    end

    // Column and row counters advance at the input, one matrix beat at a time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (elem_beat)
        begin
            if (row_done)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= is_last_row ? '0 : row_cnt_reg + mvm_pkg::ROWS_W'(1);
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + mvm_pkg::COL_AW'(1);
            end
        end
    end

    // Vector store: write on a load beat, read the current column on every advance.
    // A load always lands before any later matrix beat reads it.
    always_ff @(posedge clk)
    begin
        if (load_beat)
        begin
            vec_mem[in_index[mvm_pkg::COL_AW-1:0]] <= in_value;
        end
        if (advance)
        begin
            vec_rd_reg <= vec_mem[col_cnt_reg];
        end
    end

    // Input register, aligned with the store's read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            elem_valid_reg <= elem_beat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            elem_value_reg <= in_value;
            elem_tag_reg   <= elem_tag_next;
        end
    end

    mvm_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .elem_valid (elem_valid_reg),
        .elem_value (elem_value_reg),
        .vec_value  (vec_rd_reg),
        .elem_tag   (elem_tag_reg),
        .res_valid  (m_axis_tvalid),
        .res_sum    (res_sum),
        .res_tag    (res_tag)
    );

    assign m_axis_tdata = {res_sum, res_tag.row_index};
    assign m_axis_tlast = res_tag.last_row;

endmodule

// File: rtl/mvm_checker.sv
// Port-level checks for the matrix-vector multiplier, bound to the top level.
module mvm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result payload changed while stalled");

    // Input is taken exactly when the result register is free or draining.
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output state");

    // A new result only appears after the pipeline advanced.
    a_result_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tready))
        else $error("result appeared while the pipeline was held");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the streaming matrix-vector multiplier.
module tb_top;

    // Cycles to let the two-stage pipe empty before a register write or the end.
    localparam int SETTLE_CYCLES = 16;
    // Random input beats to queue after the directed part.
    localparam int RANDOM_BEATS  = 800;

    // One input beat as the driver sees it, with the idle cycles ahead of it.
    typedef struct {
        logic                              kind;
        logic [mvm_pkg::IDX_W-1:0]         index;
        logic signed [mvm_pkg::ELEM_W-1:0] value;
        int unsigned                       gap;
    } beat_t;

    // One finished row as it should leave the block.
    typedef struct {
        logic [mvm_pkg::ROWS_W-1:0]       row_index;
        logic signed [mvm_pkg::SUM_W-1:0] dot_product;
        logic                             last_row;
    } row_result_t;

    // Every input of the block starts from a known value.
    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [23:0]                    s_axis_tdata  = '0;   // [7:0] vector_index, [23:8] element_value
    logic                           s_axis_tuser  = 1'b0; // [0] kind
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [55:0]                    m_axis_tdata;         // [15:0] row_index, [55:16] dot_product
    logic                           m_axis_tlast;         // last_row
    logic                           cfg_valid     = 1'b0;
    logic                           cfg_ready;
    logic [mvm_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [mvm_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

    matrix_vector_multiply DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Shadow copy of the multiplier: vector store, running sum, counters, registers.
    logic signed [mvm_pkg::ELEM_W-1:0] shadow_vector [mvm_pkg::MAX_COLS];
    logic signed [mvm_pkg::SUM_W-1:0]  shadow_sum  = '0;
    int                                shadow_col  = 0;
    int                                shadow_row  = 0;
    logic [mvm_pkg::COLS_W-1:0]        shadow_cols = 9'd256;
    logic [mvm_pkg::ROWS_W-1:0]        shadow_rows = 16'd256;

    beat_t       pending_beats   [$];   // beats waiting for the driver
    row_result_t row_results_due [$];   // finished rows still to come out

    int  beats_queued    = 0;
    int  beats_accepted  = 0;
    int  results_checked = 0;
    int  mismatches      = 0;
    int  settings_used   = 0;
    bit  gaps_on         = 1'b1;
    bit  stalls_on       = 1'b1;

    // Driver bookkeeping.
    bit          staged   = 1'b0;
    int unsigned lead_cnt = 0;
    beat_t       staged_beat;
    beat_t       on_bus;

    // Monitor bookkeeping.
    int unsigned hold_cnt = 0;
    row_result_t oldest_row;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one accepted beat to the shadow state; queue the row it finishes, if any.
    task automatic accumulate_row(input beat_t b);
        int                                cols_eff;
        int                                rows_eff;
        int                                col;
        logic signed [mvm_pkg::PROD_W-1:0] prod;
        row_result_t                       done;
        if (b.kind == mvm_pkg::KIND_LOAD)
        begin
            // The index is 8 bits wide, so it always lands inside the store.
            shadow_vector[b.index] = b.value;
        end
        else
        begin
            // A zero column count acts as one; anything past the store acts as full width.
            cols_eff = (shadow_cols == 0) ? 1 : int'(shadow_cols);
            if (cols_eff > mvm_pkg::MAX_COLS)
                cols_eff = mvm_pkg::MAX_COLS;
            col  = (shadow_col < mvm_pkg::MAX_COLS) ? shadow_col : mvm_pkg::MAX_COLS - 1;
            prod = b.value * shadow_vector[col];
            shadow_sum = shadow_sum + prod;
            shadow_col++;
            // A column count already past a freshly lowered limit ends the row here.
            if (shadow_col >= cols_eff)
            begin
                rows_eff = (shadow_rows == 0) ? 1 : int'(shadow_rows);
                done.row_index   = shadow_row[mvm_pkg::ROWS_W-1:0];
                done.dot_product = shadow_sum;
                done.last_row    = (shadow_row >= rows_eff - 1);
                row_results_due.push_back(done);
                shadow_sum = '0;
                shadow_col = 0;
                // Wrap to a new matrix after the last row, keeping the stored vector.
                shadow_row = done.last_row ? 0 : ((shadow_row + 1) & 16'hFFFF);
            end
        end
    endtask

    function automatic logic signed [mvm_pkg::ELEM_W-1:0] draw_element();
        case ($urandom_range(15, 0))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return -16'sd1;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic queue_beat(input logic kind, input logic [mvm_pkg::IDX_W-1:0] index,
                              input logic signed [mvm_pkg::ELEM_W-1:0] value);
        beat_t b;
        b.kind  = kind;
        b.index = index;
        b.value = value;
        b.gap   = gaps_on ? $urandom_range(9, 0) : 0;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    // Hold until every queued beat is in and every row is out, then let the pipe empty.
    task automatic wait_until_settled();
        while (beats_accepted != beats_queued || row_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [mvm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [mvm_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == mvm_pkg::CFG_COLS_IN_USE)
            shadow_cols = data[mvm_pkg::COLS_W-1:0];
        else
            shadow_rows = data;
    endtask

    // Write both counts, in either order.
    task automatic program_counts(input logic [mvm_pkg::CFG_DATA_W-1:0] cols_data,
                                  input logic [mvm_pkg::CFG_DATA_W-1:0] rows_data);
        if ($urandom_range(1, 0) == 0)
        begin
            write_register(mvm_pkg::CFG_COLS_IN_USE, cols_data);
            write_register(mvm_pkg::CFG_ROWS_IN_USE, rows_data);
        end
        else
        begin
            write_register(mvm_pkg::CFG_ROWS_IN_USE, rows_data);
            write_register(mvm_pkg::CFG_COLS_IN_USE, cols_data);
        end
        settings_used++;
    endtask

    // Driver: present queued beats, each after its own gap; predict on every accepted beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            staged = 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                accumulate_row(on_bus);
                beats_accepted++;
            end
            // The bus slot is free when nothing is shown or the shown beat just went in.
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (!staged && pending_beats.size() != 0)
                begin
                    staged_beat = pending_beats.pop_front();
                    staged      = 1'b1;
                    lead_cnt    = staged_beat.gap;
                end
                if (staged && lead_cnt == 0)
                begin
                    on_bus = staged_beat;
                    s_axis_tdata  <= {staged_beat.value, staged_beat.index};
                    s_axis_tuser  <= staged_beat.kind;
                    s_axis_tvalid <= 1'b1;
                    staged = 1'b0;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                    if (staged)
                        lead_cnt--;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest finished row, then stall at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (row_results_due.size() == 0)
                begin
                    $error("result beat with no row outstanding: row_index %0d",
                           m_axis_tdata[15:0]);
                    mismatches++;
                end
                else
                begin
                    oldest_row = row_results_due.pop_front();
                    if (m_axis_tdata[15:0] !== oldest_row.row_index)
                    begin
                        $error("row_index: expected %0d, actual %0d",
                               oldest_row.row_index, m_axis_tdata[15:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[55:16] !== oldest_row.dot_product)
                    begin
                        $error("dot_product: expected %0d, actual %0d",
                               oldest_row.dot_product, $signed(m_axis_tdata[55:16]));
                        mismatches++;
                    end
                    if (m_axis_tlast !== oldest_row.last_row)
                    begin
                        $error("last_row: expected %0d, actual %0d",
                               oldest_row.last_row, m_axis_tlast);
                        mismatches++;
                    end
                    results_checked++;
                end
                hold_cnt = stalls_on ? $urandom_range(9, 0) : 0;
            end
            if (hold_cnt != 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cnt--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Stimulus: preload, directed cases, then random phases under fresh register settings.
    initial
    begin
        logic [mvm_pkg::CFG_DATA_W-1:0] cols_data;
        logic [mvm_pkg::CFG_DATA_W-1:0] rows_data;
        int                             n;
        int                             random_beats;
        random_beats = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the whole store first so no matrix beat ever reads an unwritten entry.
        for (int i = 0; i < mvm_pkg::MAX_COLS; i++)
            queue_beat(mvm_pkg::KIND_LOAD, 8'(i), 16'sh8000);
        // Full-width row under reset counts: largest positive sum.
        for (int i = 0; i < mvm_pkg::MAX_COLS; i++)
            queue_beat(mvm_pkg::KIND_MATRIX, 8'($urandom()), 16'sh8000);
        wait_until_settled();
        // Column count above the store width clamps; row 1 becomes the last row at once.
        program_counts(16'd300, 16'd1);
        for (int i = 0; i < mvm_pkg::MAX_COLS; i++)
            queue_beat(mvm_pkg::KIND_MATRIX, 8'($urandom()), 16'sh7FFF);
        wait_until_settled();

        // Three columns, two rows: operand extremes, a load during a row, matrix wrap.
        program_counts(16'd3, 16'd2);
        queue_beat(mvm_pkg::KIND_LOAD, 8'd0, 16'sh7FFF);
        queue_beat(mvm_pkg::KIND_LOAD, 8'd1, 16'sh8000);
        queue_beat(mvm_pkg::KIND_LOAD, 8'd2, 16'sh0001);
        queue_beat(mvm_pkg::KIND_LOAD, 8'd255, 16'sh7FFF);
        queue_beat(mvm_pkg::KIND_MATRIX, 8'd0, 16'sh8000);
        queue_beat(mvm_pkg::KIND_MATRIX, 8'd255, 16'sh7FFF);
        queue_beat(mvm_pkg::KIND_LOAD, 8'd2, -16'sd1);
        queue_beat(mvm_pkg::KIND_MATRIX, 8'd0, 16'sh0000);
        queue_beat(mvm_pkg::KIND_MATRIX, 8'd0, 16'sh7FFF);
        queue_beat(mvm_pkg::KIND_MATRIX, 8'd0, 16'sh8000);
        queue_beat(mvm_pkg::KIND_MATRIX, 8'd0, 16'sh8000);
        queue_beat(mvm_pkg::KIND_MATRIX, 8'd0, 16'sh0001);
        queue_beat(mvm_pkg::KIND_MATRIX, 8'd0, -16'sd1);
        queue_beat(mvm_pkg::KIND_MATRIX, 8'd0, 16'sd12345);
        wait_until_settled();

        // Zero counts act as one; the upper data bits of the column write are dropped.
        program_counts(16'hFE00, 16'd0);
        queue_beat(mvm_pkg::KIND_MATRIX, 8'd0, 16'sh8000);
        queue_beat(mvm_pkg::KIND_MATRIX, 8'd0, 16'sh7FFF);
        wait_until_settled();

        // Lower both counts while a row and a matrix are part way through.
        program_counts(16'd5, 16'd4);
        repeat (3) queue_beat(mvm_pkg::KIND_MATRIX, 8'($urandom()), draw_element());
        wait_until_settled();
        write_register(mvm_pkg::CFG_COLS_IN_USE, 16'd2);
        repeat (5) queue_beat(mvm_pkg::KIND_MATRIX, 8'($urandom()), draw_element());
        wait_until_settled();
        write_register(mvm_pkg::CFG_ROWS_IN_USE, 16'd2);
        repeat (2) queue_beat(mvm_pkg::KIND_MATRIX, 8'($urandom()), draw_element());
        wait_until_settled();

        // Random phases; each one ends with the sender held until every row is out.
        while (random_beats < RANDOM_BEATS)
        begin
            case ($urandom_range(9, 0))
                0:       cols_data = 16'd0;
                1:       cols_data = 16'($urandom_range(511, 256));
                2:       cols_data = 16'd1;
                default: cols_data = 16'($urandom_range(24, 1));
            endcase
            cols_data[15:9] = 7'($urandom());
            case ($urandom_range(7, 0))
                0:       rows_data = 16'd0;
                1:       rows_data = 16'd1;
                2:       rows_data = 16'hFFFF;
                3:       rows_data = 16'($urandom());
                default: rows_data = 16'($urandom_range(8, 1));
            endcase
            gaps_on   = ($urandom_range(3, 0) != 0);
            stalls_on = ($urandom_range(3, 0) != 0);
            program_counts(cols_data, rows_data);
            n = $urandom_range(140, 60);
            repeat (n)
            begin
                if ($urandom_range(99, 0) < 15)
                    queue_beat(mvm_pkg::KIND_LOAD, 8'($urandom()), draw_element());
                else
                    queue_beat(mvm_pkg::KIND_MATRIX, 8'($urandom()), draw_element());
            end
            random_beats += n;
            wait_until_settled();
        end

        $display("Run summary: %0d input beats, %0d rows checked, %0d register settings",
                 beats_accepted, results_checked, settings_used);
        $display("Covered full-width and clamped rows, zero counts, mid-row count changes, wrap");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: many times the slowest correct run.
    initial
    begin
        #(2_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/mvm_pkg.sv
rtl/mvm_mac.sv
rtl/matrix_vector_multiply.sv
rtl/mvm_checker.sv
tb/tb_top.sv
